/* rtl/kpd_pkg.sv */
// Package for the keypad digit entry block: keypad table, character codes,
// entry modes, display actions and the result word layout.
// No dependencies.
package kpd_pkg;

	typedef enum logic [1:0] {
		MODE_NUMBER   = 2'd0,
		MODE_PASSWORD = 2'd1,
		MODE_ID       = 2'd2,
		MODE_ID_ALT   = 2'd3
	} entry_mode_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_SHOW  = 2'd1,
		ACT_MASK  = 2'd2,
		ACT_ERASE = 2'd3
	} disp_action_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_BKSP  = 8'h42; // 'B'
	localparam logic [7:0] CHAR_ENTER = 8'h3D; // '='
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	localparam int unsigned ACC_W = 14;
	localparam logic [ACC_W-1:0] ACC_MAX = 14'h3FFF;
	// x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 14-bit x
	localparam logic [15:0] RECIP_10 = 16'd52429;
	localparam int unsigned RECIP_SHIFT = 19;

	typedef struct packed {
		logic         aborted;
		logic [15:0]  entry_digits;
		logic [13:0]  entry_value;
		logic         entry_done;
		logic [7:0]   disp_char;
		disp_action_t disp_action;
	} result_t;

	function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col);
		logic [7:0] c;
		case ({row, col})
			4'h0: c = 8'h31; // '1'
			4'h1: c = 8'h32;
			4'h2: c = 8'h33;
			4'h3: c = 8'h41; // 'A'
			4'h4: c = 8'h34;
			4'h5: c = 8'h35;
			4'h6: c = 8'h36;
			4'h7: c = CHAR_BKSP;
			4'h8: c = 8'h37;
			4'h9: c = 8'h38;
			4'hA: c = 8'h39;
			4'hB: c = 8'h2D; // '-'
			4'hC: c = 8'h2A; // '*'
			4'hD: c = CHAR_ZERO;
			4'hE: c = CHAR_ENTER;
			4'hF: c = CHAR_BKSP;
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

endpackage

/* rtl/keypad_digit_entry.sv */
// Keypad digit entry top level: key decode, digit/value state and a two-word
// output buffer (result register plus skid register).
// Depends on kpd_pkg.
//
// Usage:
//  s_* channel: one word per key event. s_tdata[1:0] key_row, [3:2] key_col,
//  s_tuser is the abort flag. A word is taken when s_tvalid and s_tready are high.
//  m_* channel: one result word per key event, in order. m_tuser is disp_action,
//  m_tdata carries disp_char, entry_done, entry_value, entry_digits, aborted.
//  cfg_we/cfg_data write entry_mode; write only while no word is in flight.
//  Results reach m_* from the result register, via the skid register under a stall.
//  Throughput: one key word per cycle while the skid register is empty; the state
//  update (digit count, value times ten plus digit, reciprocal divide by ten on
//  backspace) is combinational between input handshake and result register.
//  When the receiver stalls, one more key word is taken into the skid register;
//  s_tready then drops until the result register drains.
//  Reset clears entry_mode, the digit count, the value and both buffer valid flags;
//  the held digits themselves are not cleared and are only read below the count.
module keypad_digit_entry #(
	parameter int unsigned MAX_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data,   // entry_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [1:0] key_row, [3:2] key_col, [7:4] zero
	input  logic        s_tuser,    // abort
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // [7:0] disp_char, [8] entry_done,
	                                // [22:9] entry_value, [38:23] entry_digits,
	                                // [39] aborted
	output logic [1:0]  m_tuser     // disp_action
);
	import kpd_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);

	entry_mode_t      mode_q;
	logic [CNT_W-1:0] digit_count_q;
	logic [ACC_W-1:0] number_acc_q;
	logic [3:0]       digit_store_q [MAX_DIGITS];

	result_t res_s1, skid_q, res_next;
	logic    out_valid_s1, skid_valid_q;
	logic    accept;

	logic [7:0]       key;
	logic             is_digit, number_mode;
	logic [3:0]       digit;
	logic [17:0]      acc_next_wide;
	logic [ACC_W-1:0] acc_next_sat;
	logic [29:0]      div_prod;
	logic [ACC_W-1:0] acc_div10;
	logic [4*MAX_DIGITS-1:0]  packed_digits;
	logic [4*MAX_DIGITS+15:0] packed_ext;
	logic enter_ok;

	logic             st_we, st_count_we;
	logic [CNT_W-1:0] count_next;
	logic [ACC_W-1:0] acc_next;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	assign key         = key_char(s_tdata[1:0], s_tdata[3:2]);
	assign is_digit    = (key >= CHAR_ZERO) && (key <= CHAR_NINE);
	assign digit       = 4'(key - CHAR_ZERO);
	assign number_mode = (mode_q == MODE_NUMBER);

	assign acc_next_wide = 18'(number_acc_q) * 18'd10 + 18'(digit);
	assign acc_next_sat  = (acc_next_wide > 18'(ACC_MAX)) ? ACC_MAX : acc_next_wide[ACC_W-1:0];
	assign div_prod      = 30'(number_acc_q) * 30'(RECIP_10);
	assign acc_div10     = ACC_W'(div_prod[29:RECIP_SHIFT]);

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			packed_digits[4*(MAX_DIGITS-1-i) +: 4] = digit_store_q[i];
		end
	end
	assign packed_ext = {16'd0, packed_digits};

	assign enter_ok = number_mode ? (digit_count_q != '0) : (digit_count_q == CNT_FULL);

	always_comb begin
		res_next    = '0;
		res_next.disp_action = ACT_NONE;
		st_we       = 1'b0;
		st_count_we = 1'b0;
		count_next  = digit_count_q;
		acc_next    = number_acc_q;
		if (s_tuser) begin
			if (number_mode) begin
				st_count_we      = 1'b1;
				count_next       = '0;
				acc_next         = '0;
				res_next.aborted = 1'b1;
			end
		end else if (is_digit) begin
			if (digit_count_q < CNT_FULL) begin
				st_we       = 1'b1;
				st_count_we = 1'b1;
				count_next  = digit_count_q + CNT_W'(1);
				acc_next    = acc_next_sat;
				res_next.disp_action = (mode_q == MODE_PASSWORD) ? ACT_MASK : ACT_SHOW;
				res_next.disp_char   = key;
			end
		end else if (key == CHAR_BKSP) begin
			if (digit_count_q != '0) begin
				st_count_we = 1'b1;
				count_next  = digit_count_q - CNT_W'(1);
				acc_next    = acc_div10;
				res_next.disp_action = ACT_ERASE;
				res_next.disp_char   = CHAR_SPACE;
			end
		end else if (key == CHAR_ENTER) begin
			if (enter_ok) begin
				st_count_we         = 1'b1;
				count_next          = '0;
				acc_next            = '0;
				res_next.entry_done = 1'b1;
				if (number_mode) begin
					res_next.entry_value = number_acc_q;
				end else begin
					res_next.entry_digits = packed_ext[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_NUMBER;
			digit_count_q <= '0;
			number_acc_q  <= '0;
			out_valid_s1  <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= entry_mode_t'(cfg_data);
			end
			if (accept && st_count_we) begin
				digit_count_q <= count_next;
				number_acc_q  <= acc_next;
			end
			if (!out_valid_s1 || m_tready) begin
				out_valid_s1 <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept && st_we) begin
			digit_store_q[digit_count_q[IDX_W-1:0]] <= digit;
		end
		if (!out_valid_s1 || m_tready) begin
			if (skid_valid_q) begin
				res_s1 <= skid_q;
			end else if (accept) begin
				res_s1 <= res_next;
			end
		end else if (accept) begin
			skid_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_s1;
	assign m_tuser  = res_s1.disp_action;
	assign m_tdata  = {res_s1.aborted, res_s1.entry_digits, res_s1.entry_value,
	                   res_s1.entry_done, res_s1.disp_char};

`ifndef NO_ASSERTIONS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_s1)
		else $error("skid word held with empty result register");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= CNT_FULL)
		else $error("digit count above maximum");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_valid_s1 && !m_tready) |=> skid_valid_q)
		else $error("word accepted under stall was not buffered");

	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser && number_mode) |=> (digit_count_q == '0 && number_acc_q == '0))
		else $error("abort in number mode did not clear entry");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_next.entry_done) |=> (digit_count_q == '0))
		else $error("completed entry did not clear digit count");
`endif

endmodule

/* bench/keypad_digit_entry_tb.sv */
// Self-checking bench for keypad_digit_entry: directed and random key words on the
// s_* stream, per-word prediction of the display/entry result, checked on m_* stream.
// Depends on kpd_pkg and the keypad_digit_entry RTL.
module keypad_digit_entry_tb;
	import kpd_pkg::*;

	localparam int MAX_DIGITS  = 4;
	localparam int HOLD_CYCLES = 90;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 76;

	// keypad layout, index {row, col}
	localparam logic [7:0] KEYPAD [16] = '{
		"1", "2", "3", "A",
		"4", "5", "6", "B",
		"7", "8", "9", "-",
		"*", "0", "=", "B"
	};

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		logic       abrt;
	} key_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_data = 2'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	keypad_digit_entry #(.MAX_DIGITS(MAX_DIGITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	key_word_t   pending_keys[$];
	result_t     expected_results[$];

	// predictor state
	entry_mode_t cur_mode = MODE_NUMBER;
	int unsigned held_count = 0;
	logic [13:0] held_value = '0;
	logic [3:0]  held_digits [MAX_DIGITS];

	int src_idle = 20;
	int snk_idle = 20;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int gap_pick;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;

	int errors = 0;
	int cycles = 0;
	int n_queued = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_done = 0;
	int n_aborted = 0;
	int n_stalled = 0;
	int modes_seen = 0;

	function automatic int pick_gap(int pct);
		int r;
		if ($urandom_range(0, 99) >= pct)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		else if (r < 9)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic result_t predict_entry(key_word_t w);
		result_t     r;
		logic [7:0]  key;
		logic [3:0]  d;
		int unsigned next;
		logic [63:0] packed_bcd;
		logic        number_mode;
		r = '0;
		key = KEYPAD[{w.row, w.col}];
		number_mode = (cur_mode == MODE_NUMBER);
		if (w.abrt) begin
			// abort only counts in number mode; the key is ignored either way
			if (number_mode) begin
				held_count = 0;
				held_value = '0;
				r.aborted = 1'b1;
			end
		end else if (key >= CHAR_ZERO && key <= CHAR_NINE) begin
			if (held_count < MAX_DIGITS) begin
				d = 4'(key - CHAR_ZERO);
				next = held_value * 10 + d;
				held_digits[held_count] = d;
				held_count++;
				held_value = (next > ACC_MAX) ? ACC_MAX : 14'(next);
				r.disp_action = (cur_mode == MODE_PASSWORD) ? ACT_MASK : ACT_SHOW;
				r.disp_char = key;
			end
		end else if (key == CHAR_BKSP) begin
			if (held_count != 0) begin
				held_count--;
				held_value = held_value / 10;
				r.disp_action = ACT_ERASE;
				r.disp_char = CHAR_SPACE;
			end
		end else if (key == CHAR_ENTER) begin
			if (number_mode ? (held_count != 0) : (held_count == MAX_DIGITS)) begin
				r.entry_done = 1'b1;
				if (number_mode) begin
					r.entry_value = held_value;
				end else begin
					packed_bcd = '0;
					for (int i = 0; i < MAX_DIGITS; i++)
						packed_bcd = {packed_bcd[59:0], held_digits[i]};
					r.entry_digits = packed_bcd[15:0];
				end
				held_count = 0;
				held_value = '0;
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	// source side: one word per handshake, random gaps between words
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_entry(
					key_word_t'({s_tdata[1:0], s_tdata[3:2], s_tuser})));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_keys.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'd0, pending_keys[0].col, pending_keys[0].row};
					s_tuser <= pending_keys[0].abrt;
					void'(pending_keys.pop_front());
					// keep offering words while the sink holds off
					gap_left <= (hold_left != 0) ? 0 : pick_gap(src_idle);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		result_t got, exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'({m_tdata, m_tuser});
				n_checked++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, got %h", $time, got);
				end else begin
					exp_r = expected_results.pop_front();
					check_field("disp_action", 16'(exp_r.disp_action), 16'(got.disp_action));
					check_field("disp_char", 16'(exp_r.disp_char), 16'(got.disp_char));
					check_field("entry_done", 16'(exp_r.entry_done), 16'(got.entry_done));
					check_field("entry_value", 16'(exp_r.entry_value), 16'(got.entry_value));
					check_field("entry_digits", exp_r.entry_digits, got.entry_digits);
					check_field("aborted", 16'(exp_r.aborted), 16'(got.aborted));
					if (exp_r.entry_done)
						n_done++;
					if (exp_r.aborted)
						n_aborted++;
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
				if (!s_tready)
					n_stalled++;
			end else if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				gap_pick = pick_gap(snk_idle);
				if (gap_pick > 0) begin
					stall_left <= gap_pick - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycles, expected_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_word(logic [1:0] row, logic [1:0] col, logic abrt);
		key_word_t w;
		w.row = row;
		w.col = col;
		w.abrt = abrt;
		pending_keys.push_back(w);
		n_queued++;
	endtask

	task automatic queue_key(logic [7:0] ch);
		int hits[$];
		int pos;
		for (int i = 0; i < 16; i++)
			if (KEYPAD[i] == ch)
				hits.push_back(i);
		// backspace sits at two places on the pad
		pos = hits[$urandom_range(0, hits.size() - 1)];
		queue_word(2'(pos >> 2), 2'(pos), 1'b0);
	endtask

	task automatic queue_abort();
		queue_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b1);
	endtask

	task automatic queue_digit();
		queue_key(8'(CHAR_ZERO + $urandom_range(0, 9)));
	endtask

	// one entry sequence with random content, sometimes broken, or a noise word
	task automatic queue_entry();
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			queue_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 3) == 0));
			return;
		end
		n = (cur_mode == MODE_NUMBER) ? $urandom_range(1, MAX_DIGITS) : MAX_DIGITS;
		if (r < 16)
			n = $urandom_range(0, MAX_DIGITS - 1);
		else if (r < 21)
			n = MAX_DIGITS + 1;
		for (int i = 0; i < n; i++) begin
			queue_digit();
			if ($urandom_range(0, 9) == 0) begin
				queue_key(CHAR_BKSP);
				queue_digit();
			end
			if ($urandom_range(0, 39) == 0)
				queue_abort();
		end
		queue_key(CHAR_ENTER);
	endtask

	task automatic drain();
		while (pending_keys.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(entry_mode_t m);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode = m;
		modes_seen++;
	endtask

	initial begin
		entry_mode_t phase_modes [8];
		phase_modes = '{MODE_ID, MODE_NUMBER, MODE_PASSWORD, MODE_ID_ALT,
			MODE_NUMBER, MODE_ID, MODE_PASSWORD, MODE_NUMBER};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// number mode out of reset: empty backspace/enter, full pad, erase, abort
		queue_key(CHAR_BKSP);
		queue_key(CHAR_ENTER);
		queue_key("1");
		queue_key("2");
		queue_key("3");
		queue_key("4");
		queue_key("5");
		queue_key(CHAR_BKSP);
		queue_key("9");
		queue_key(CHAR_ENTER);
		queue_key("7");
		queue_abort();
		queue_key("A");
		queue_key("-");
		queue_key("*");

		// password: masked echo, abort ignored, short enter refused
		set_mode(MODE_PASSWORD);
		queue_key("3");
		queue_abort();
		queue_key(CHAR_ENTER);
		queue_key(CHAR_BKSP);
		queue_key("0");
		queue_key("9");
		queue_key("8");
		queue_key("7");
		queue_key(CHAR_ENTER);

		// alternate code behaves as ID entry
		set_mode(MODE_ID_ALT);
		queue_key("4");
		queue_key("5");
		queue_key("6");
		queue_key("0");
		queue_key(CHAR_ENTER);

		for (int p = 0; p < 8; p++) begin
			set_mode(phase_modes[p]);
			case (p % 4)
				0: begin src_idle = 0; snk_idle = 0; end
				1: begin src_idle = 30; snk_idle = 10; end
				2: begin src_idle = 10; snk_idle = 40; end
				default: begin src_idle = 50; snk_idle = 50; end
			endcase
			if (p == 2) begin
				src_idle = 0;
				@(posedge clk);
				hold_req <= 1'b1;
			end
			n_queued = 0;
			while (n_queued < PHASE_WORDS)
				queue_entry();
		end

		drain();
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d expected words never arrived", $time, expected_results.size());
		end
		$display("%0d key words sent, %0d result words checked, %0d mode writes",
			n_sent, n_checked, modes_seen);
		$display("%0d entries completed, %0d aborts, input stalled %0d cycles under hold-off",
			n_done, n_aborted, n_stalled);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
rtl/kpd_pkg.sv
rtl/keypad_digit_entry.sv
bench/keypad_digit_entry_tb.sv
